// File: rtl/core/osm_pkg.sv
// Shared types and constants for the order-statistic multiset.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package osm_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_RANK   = 3'd2;
  localparam logic [2:0] CMD_KTH    = 3'd3;
  localparam logic [2:0] CMD_PRED   = 3'd4;
  localparam logic [2:0] CMD_SUCC   = 3'd5;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_NONE  = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] operand;
  } osm_in_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
  } osm_out_t;

  typedef struct packed {
    logic     valid;
    osm_out_t data;
  } osm_res_t;

endpackage

// File: rtl/core/osm_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on osm_pkg for depth and address width.
`timescale 1ns / 1ps
module osm_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [osm_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]                wdata,
  input  logic                       re,
  input  logic [osm_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]                rdata
);
  import osm_pkg::*;

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/osm_engine.sv
// Command sequencer: binary search, fetch and entry shifting over osm_ram.
// Depends on osm_pkg and osm_ram.
`timescale 1ns / 1ps
module osm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  osm_pkg::osm_in_t  cmd_data,
  output logic              cmd_ready,
  output osm_pkg::osm_res_t res,
  input  logic              res_ready
);
  import osm_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_SEARCH  = 10'b0000000010,
    ST_COMPARE = 10'b0000000100,
    ST_CHECK   = 10'b0000001000,
    ST_FETCH   = 10'b0000010000,
    ST_UP_RD   = 10'b0000100000,
    ST_UP_WR   = 10'b0001000000,
    ST_DN_RD   = 10'b0010000000,
    ST_DN_WR   = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             below_r, below_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [31:0]      ans_r, ans_nxt;
  logic [1:0]       sts_r, sts_nxt;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata, rdata;
  logic [CNT_W:0]    sum;
  logic [32:0]       ke, kv;
  logic              go_right;

  osm_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // signed order via flipped sign bit
  assign ke = {1'b0, ~rdata[31], rdata[30:0]};
  assign kv = {1'b0, ~val_r[31], val_r[30:0]};
  assign go_right = below_r ? (ke < kv) : (ke <= kv);
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};

  assign cmd_ready = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.data.answer = ans_r;
  assign res.data.status = sts_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    below_nxt = below_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    mid_nxt   = mid_r;
    ans_nxt   = ans_r;
    sts_nxt   = sts_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = val_r;
    re        = 1'b0;
    raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd_data.cmd;
          val_nxt   = cmd_data.operand;
          below_nxt = (cmd_data.cmd == CMD_DELETE) || (cmd_data.cmd == CMD_RANK) ||
                      (cmd_data.cmd == CMD_PRED);
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          ans_nxt   = '0;
          sts_nxt   = STS_OK;
          case (cmd_data.cmd)
            CMD_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                sts_nxt   = STS_FULL;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SEARCH;
              end
            end
            CMD_DELETE, CMD_RANK, CMD_PRED, CMD_SUCC: state_nxt = ST_SEARCH;
            CMD_KTH: begin
              if (!cmd_data.operand[31] && cmd_data.operand != 32'sd0 &&
                  cmd_data.operand[30:0] <= 31'(cnt_r)) begin
                re        = 1'b1;
                raddr     = ADDR_W'(cmd_data.operand - 32'sd1);
                state_nxt = ST_FETCH;
              end else begin
                sts_nxt   = STS_NONE;
                state_nxt = ST_DONE;
              end
            end
            default: begin
              sts_nxt   = STS_NONE;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = sum[ADDR_W:1];
          re        = 1'b1;
          raddr     = sum[ADDR_W:1];
          state_nxt = ST_COMPARE;
        end else begin
          // lo_r holds the position found by the search
          case (cmd_r)
            CMD_INSERT: begin
              idx_nxt   = cnt_r;
              state_nxt = ST_UP_RD;
            end
            CMD_DELETE: begin
              if (lo_r < cnt_r) begin
                re        = 1'b1;
                raddr     = lo_r[ADDR_W-1:0];
                state_nxt = ST_CHECK;
              end else begin
                sts_nxt   = STS_NONE;
                state_nxt = ST_DONE;
              end
            end
            CMD_RANK: begin
              ans_nxt   = 32'(lo_r) + 32'd1;
              state_nxt = ST_DONE;
            end
            CMD_PRED: begin
              if (lo_r != '0) begin
                re        = 1'b1;
                raddr     = ADDR_W'(lo_r - CNT_W'(1));
                state_nxt = ST_FETCH;
              end else begin
                sts_nxt   = STS_NONE;
                state_nxt = ST_DONE;
              end
            end
            default: begin
              if (lo_r < cnt_r) begin
                re        = 1'b1;
                raddr     = lo_r[ADDR_W-1:0];
                state_nxt = ST_FETCH;
              end else begin
                sts_nxt   = STS_NONE;
                state_nxt = ST_DONE;
              end
            end
          endcase
        end
      end
      ST_COMPARE: begin
        if (go_right) begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end else begin
          hi_nxt = CNT_W'(mid_r);
        end
        state_nxt = ST_SEARCH;
      end
      ST_CHECK: begin
        if (rdata == val_r) begin
          idx_nxt   = lo_r;
          state_nxt = ST_DN_RD;
        end else begin
          sts_nxt   = STS_NONE;
          state_nxt = ST_DONE;
        end
      end
      ST_FETCH: begin
        ans_nxt   = rdata;
        state_nxt = ST_DONE;
      end
      ST_UP_RD: begin
        if (idx_r > lo_r) begin
          re        = 1'b1;
          raddr     = ADDR_W'(idx_r - CNT_W'(1));
          state_nxt = ST_UP_WR;
        end else begin
          we        = 1'b1;
          waddr     = lo_r[ADDR_W-1:0];
          wdata     = val_r;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_UP_WR: begin
        we        = 1'b1;
        waddr     = idx_r[ADDR_W-1:0];
        wdata     = rdata;
        idx_nxt   = idx_r - CNT_W'(1);
        state_nxt = ST_UP_RD;
      end
      ST_DN_RD: begin
        if (idx_r + CNT_W'(1) < cnt_r) begin
          re        = 1'b1;
          raddr     = ADDR_W'(idx_r + CNT_W'(1));
          state_nxt = ST_DN_WR;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DN_WR: begin
        we        = 1'b1;
        waddr     = idx_r[ADDR_W-1:0];
        wdata     = rdata;
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = ST_DN_RD;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    val_r   <= val_nxt;
    below_r <= below_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    idx_r   <= idx_nxt;
    mid_r   <= mid_nxt;
    ans_r   <= ans_nxt;
    sts_r   <= sts_nxt;
  end

endmodule

// File: rtl/core/order_statistic_multiset.sv
// Sorted multiset of signed 32-bit values with rank, k-th, predecessor and
// successor queries. One command is worked at a time. Each step of a query's
// binary search reads the entry RAM in ST_SEARCH and uses the registered read
// data in ST_COMPARE. Insert and delete move entries one at a time, with
// a read state and a write state per entry moved to open or close the gap.
// The result sits in an output register, so the next command is taken while
// an earlier result still waits. No clearing pass after reset is needed.
// Top level; depends on osm_pkg and osm_engine.
`timescale 1ns / 1ps
module order_statistic_multiset (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  osm_pkg::osm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output osm_pkg::osm_out_t out_data
);
  import osm_pkg::*;

  logic     cmd_ready, res_ready;
  osm_res_t res;
  logic     out_valid_r, out_valid_nxt;
  osm_out_t out_data_r;

  osm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_data  (in_data),
    .cmd_ready (cmd_ready),
    .res       (res),
    .res_ready (res_ready)
  );

  assign in_stall  = !cmd_ready;
  assign res_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_data_r <= res.data;
    end
  end

endmodule
